>>> sv/sync_length_frame_deframer_core_defines.svh
// Assertion macros for the sync/length frame deframer.
// Included by the top level only; relies on nothing else.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication under reset.
`define SLFD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define SLFD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/slfd_pkg.sv
// Shared types and constants of the sync/length frame deframer.
// Used by slfd_ctrl, slfd_datapath and the top level.
package slfd_pkg;

  localparam logic [7:0] SYNC1_BYTE = 8'h55;
  localparam logic [7:0] SYNC2_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h03;
  localparam logic [8:0] LEN_SUM    = 9'h0FF;
  localparam int unsigned MIN_SCAN_FILL = 7;
  localparam int unsigned HDR_BYTES     = 4;
  localparam int unsigned FRAME_EXTRA   = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SYNC1,
    ST_SYNC2,
    ST_LEN,
    ST_CPL,
    ST_END,
    ST_SUM,
    ST_EMIT
  } state_e;

  // Window offset of the byte to read, relative to the head.
  typedef enum logic [2:0] {
    OFF_HEAD,
    OFF_SYNC2,
    OFF_LEN,
    OFF_CPL,
    OFF_END,
    OFF_DATA0,
    OFF_NEXT
  } off_sel_e;

  typedef enum logic [1:0] {
    DROP_1,
    DROP_2,
    DROP_4,
    DROP_FRAME
  } drop_sel_e;

  typedef struct packed {
    logic      wr;
    logic      rd_en;
    off_sel_e  off_sel;
    logic      drop_en;
    drop_sel_e drop_sel;
    logic      len_ld;
    logic      csum_clr;
    logic      csum_acc;
    logic      ok_ld;
    logic      idx_clr;
    logic      idx_inc;
    logic      out_ld;
    logic      out_empty;
  } cmd_t;

  typedef struct packed {
    logic fill_ge7;
    logic win_full;
    logic rd_is_sync1;
    logic rd_is_sync2;
    logic rd_is_end;
    logic len_bad;
    logic frame_short;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

>>> sv/sync_length_frame_deframer_core.sv
// Deframer for 55 AA L ~L d0..d(L-1) 03 frames arriving one byte per transfer.
// Bytes go into a circular window of MAX_DATA_LEN+5 entries in a single-port-read
// memory; after each byte the sequencer rescans the head while 7 or more bytes are
// held, reading at most one window byte per cycle. A good header whose frame is not
// yet complete waits for further bytes; each failed sync, length or end byte check
// drops bytes at the head before the next rescan; an accepted frame adds a checksum
// pass and an output pass over the window, and the output pass waits while the
// output side stalls. Results leave through an output register, so the scan goes on
// while the last result waits.
// No clearing pass after reset: window entries are only read once written.
module sync_length_frame_deframer_core #(
  parameter int unsigned MAX_DATA_LEN = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic [4:0] byte_index_o,
  output logic [4:0] frame_length_o,
  output logic       is_last_o,
  output logic       checksum_ok_o,
  output logic       empty_frame_o
);

  `include "sync_length_frame_deframer_core_defines.svh"

  slfd_pkg::cmd_t cmd;
  slfd_pkg::sts_t sts;

  slfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slfd_datapath #(
    .MAX_DATA_LEN (MAX_DATA_LEN)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .is_last_o      (is_last_o),
    .checksum_ok_o  (checksum_ok_o),
    .empty_frame_o  (empty_frame_o)
  );

  `SLFD_ASSERT_IMP(a_no_full_on_write, clk_i, rst_ni,
    in_valid_i && !in_stall_o, !sts.win_full, "byte window full on input transfer")
  `SLFD_ASSERT_IMP(a_load_when_free, clk_i, rst_ni,
    cmd.out_ld, sts.out_free, "result register overwritten before transfer")
  `SLFD_ASSERT_NXT(a_scan_after_write, clk_i, rst_ni,
    in_valid_i && !in_stall_o, in_stall_o, "scan did not follow input transfer")
  `SLFD_ASSERT_IMP(a_last_index, clk_i, rst_ni,
    out_valid_o && is_last_o && !empty_frame_o,
    5'(byte_index_o + 5'd1) == frame_length_o, "last mark on wrong byte index")

endmodule

>>> sv/slfd_ctrl.sv
// Scan sequencer of the sync/length frame deframer.
// Depends on slfd_pkg; drives slfd_datapath through cmd_t and reads sts_t.
module slfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  slfd_pkg::sts_t sts_i,
  output slfd_pkg::cmd_t cmd_o
);

  slfd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != slfd_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slfd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = slfd_pkg::ST_CHECK;
      end
      slfd_pkg::ST_CHECK: begin
        state_d = sts_i.fill_ge7 ? slfd_pkg::ST_SYNC1 : slfd_pkg::ST_IDLE;
      end
      slfd_pkg::ST_SYNC1: begin
        state_d = sts_i.rd_is_sync1 ? slfd_pkg::ST_SYNC2 : slfd_pkg::ST_CHECK;
      end
      slfd_pkg::ST_SYNC2: begin
        state_d = sts_i.rd_is_sync2 ? slfd_pkg::ST_LEN : slfd_pkg::ST_CHECK;
      end
      slfd_pkg::ST_LEN: begin
        state_d = slfd_pkg::ST_CPL;
      end
      slfd_pkg::ST_CPL: begin
        if (sts_i.len_bad) state_d = slfd_pkg::ST_CHECK;
        else if (sts_i.frame_short) state_d = slfd_pkg::ST_IDLE;
        else state_d = slfd_pkg::ST_END;
      end
      slfd_pkg::ST_END: begin
        if (!sts_i.rd_is_end) state_d = slfd_pkg::ST_CHECK;
        else if (!sts_i.len_zero) state_d = slfd_pkg::ST_SUM;
        else if (sts_i.out_free) state_d = slfd_pkg::ST_CHECK;
      end
      slfd_pkg::ST_SUM: begin
        if (sts_i.idx_last) state_d = slfd_pkg::ST_EMIT;
      end
      slfd_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.idx_last) state_d = slfd_pkg::ST_CHECK;
      end
      default: state_d = slfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      slfd_pkg::ST_IDLE: begin
        cmd_o.wr = in_valid_i;
      end
      slfd_pkg::ST_CHECK: begin
        cmd_o.rd_en   = sts_i.fill_ge7;
        cmd_o.off_sel = slfd_pkg::OFF_HEAD;
      end
      slfd_pkg::ST_SYNC1: begin
        if (sts_i.rd_is_sync1) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.off_sel = slfd_pkg::OFF_SYNC2;
        end else begin
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = slfd_pkg::DROP_1;
        end
      end
      slfd_pkg::ST_SYNC2: begin
        if (sts_i.rd_is_sync2) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.off_sel = slfd_pkg::OFF_LEN;
        end else begin
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = slfd_pkg::DROP_2;
        end
      end
      slfd_pkg::ST_LEN: begin
        cmd_o.len_ld  = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.off_sel = slfd_pkg::OFF_CPL;
      end
      slfd_pkg::ST_CPL: begin
        if (sts_i.len_bad) begin
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = slfd_pkg::DROP_4;
        end else if (!sts_i.frame_short) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.off_sel = slfd_pkg::OFF_END;
        end
      end
      slfd_pkg::ST_END: begin
        if (!sts_i.rd_is_end) begin
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = slfd_pkg::DROP_1;
        end else if (!sts_i.len_zero) begin
          cmd_o.csum_clr = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.off_sel  = slfd_pkg::OFF_DATA0;
        end else if (sts_i.out_free) begin
          // empty frame: one marker transfer
          cmd_o.out_ld    = 1'b1;
          cmd_o.out_empty = 1'b1;
          cmd_o.drop_en   = 1'b1;
          cmd_o.drop_sel  = slfd_pkg::DROP_FRAME;
        end
      end
      slfd_pkg::ST_SUM: begin
        if (sts_i.idx_last) begin
          cmd_o.ok_ld   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.off_sel = slfd_pkg::OFF_DATA0;
        end else begin
          cmd_o.csum_acc = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.off_sel  = slfd_pkg::OFF_NEXT;
        end
      end
      slfd_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.drop_en  = 1'b1;
            cmd_o.drop_sel = slfd_pkg::DROP_FRAME;
          end else begin
            cmd_o.idx_inc = 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.off_sel = slfd_pkg::OFF_NEXT;
          end
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/slfd_datapath.sv
// Byte window memory, head/fill pointers, checksum and result register.
// Depends on slfd_pkg; commanded by slfd_ctrl.
module slfd_datapath #(
  parameter int unsigned MAX_DATA_LEN = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slfd_pkg::cmd_t cmd_i,
  output slfd_pkg::sts_t sts_o,
  input  logic [7:0]     rx_byte_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     data_byte_o,
  output logic [4:0]     byte_index_o,
  output logic [4:0]     frame_length_o,
  output logic           is_last_o,
  output logic           checksum_ok_o,
  output logic           empty_frame_o
);

  localparam int unsigned Depth = MAX_DATA_LEN + slfd_pkg::FRAME_EXTRA;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned FW    = $clog2(Depth + 1);

  logic [7:0]    win_mem [Depth];
  logic [7:0]    rd_q;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    len_q;
  logic [7:0]    idx_q;
  logic [7:0]    csum_q;
  logic          ok_q;
  logic          out_valid_q;

  logic [AW-1:0] off;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  logic [FW-1:0] drop_n;
  logic [AW:0]   head_sum;
  logic          do_wr;

  // Offsets stay below Depth, so one compare-subtract wraps the address.
  always_comb begin
    case (cmd_i.off_sel)
      slfd_pkg::OFF_HEAD:  off = '0;
      slfd_pkg::OFF_SYNC2: off = AW'(1);
      slfd_pkg::OFF_LEN:   off = AW'(2);
      slfd_pkg::OFF_CPL:   off = AW'(3);
      slfd_pkg::OFF_END:   off = AW'(len_q) + AW'(slfd_pkg::HDR_BYTES);
      slfd_pkg::OFF_DATA0: off = AW'(slfd_pkg::HDR_BYTES);
      slfd_pkg::OFF_NEXT:  off = AW'(idx_q) + AW'(slfd_pkg::HDR_BYTES + 1);
      default:             off = '0;
    endcase
  end

  assign rd_sum  = {1'b0, head_q} + {1'b0, off};
  assign rd_addr = (rd_sum >= (AW+1)'(Depth)) ? AW'(rd_sum - (AW+1)'(Depth)) : AW'(rd_sum);
  assign wr_sum  = {1'b0, head_q} + (AW+1)'(fill_q);
  assign wr_addr = (wr_sum >= (AW+1)'(Depth)) ? AW'(wr_sum - (AW+1)'(Depth)) : AW'(wr_sum);
  assign do_wr   = cmd_i.wr && !sts_o.win_full;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      win_mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= win_mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.drop_sel)
      slfd_pkg::DROP_1:     drop_n = FW'(1);
      slfd_pkg::DROP_2:     drop_n = FW'(2);
      slfd_pkg::DROP_4:     drop_n = FW'(4);
      slfd_pkg::DROP_FRAME: drop_n = FW'(len_q) + FW'(slfd_pkg::FRAME_EXTRA);
      default:              drop_n = '0;
    endcase
  end

  // A drop never exceeds the fill while scanning.
  assign head_sum = {1'b0, head_q} + (AW+1)'(drop_n);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (do_wr) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.drop_en) begin
      head_d = (head_sum >= (AW+1)'(Depth)) ? AW'(head_sum - (AW+1)'(Depth))
                                            : AW'(head_sum);
      fill_d = fill_q - drop_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_ld) len_q <= rd_q;
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 8'd1;
    end
    if (cmd_i.csum_clr) begin
      csum_q <= '0;
    end else if (cmd_i.csum_acc) begin
      csum_q <= csum_q ^ rd_q;
    end
    if (cmd_i.ok_ld) ok_q <= (csum_q == rd_q);
    if (cmd_i.out_ld) begin
      if (cmd_i.out_empty) begin
        data_byte_o   <= '0;
        byte_index_o  <= '0;
        is_last_o     <= 1'b1;
        checksum_ok_o <= 1'b0;
      end else begin
        data_byte_o   <= rd_q;
        byte_index_o  <= idx_q[4:0];
        is_last_o     <= sts_o.idx_last;
        checksum_ok_o <= ok_q;
      end
      frame_length_o <= len_q[4:0];
      empty_frame_o  <= cmd_i.out_empty;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.fill_ge7    = (fill_q >= FW'(slfd_pkg::MIN_SCAN_FILL));
  assign sts_o.win_full    = (fill_q == FW'(Depth));
  assign sts_o.rd_is_sync1 = (rd_q == slfd_pkg::SYNC1_BYTE);
  assign sts_o.rd_is_sync2 = (rd_q == slfd_pkg::SYNC2_BYTE);
  assign sts_o.rd_is_end   = (rd_q == slfd_pkg::END_BYTE);
  assign sts_o.len_bad     = (({1'b0, len_q} + {1'b0, rd_q}) != slfd_pkg::LEN_SUM) ||
                             (len_q > 8'(MAX_DATA_LEN));
  assign sts_o.frame_short = (9'(fill_q) <= ({1'b0, len_q} + 9'(slfd_pkg::HDR_BYTES)));
  assign sts_o.len_zero    = (len_q == 8'd0);
  assign sts_o.idx_last    = ((idx_q + 8'd1) == len_q);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

>>> tb/sync_length_frame_deframer_core_tb.sv
// Self-checking bench for sync_length_frame_deframer_core: random and directed byte
// streams, a behavioural deframer as predictor, and random idling on both channels.
// Depends on slfd_pkg and the core itself.
module sync_length_frame_deframer_core_tb;
  import slfd_pkg::*;

  localparam int unsigned MAX_DATA_LEN = 20;
  localparam int unsigned WIN_DEPTH    = MAX_DATA_LEN + FRAME_EXTRA;
  localparam int STIM_BYTES  = 420;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic [4:0] frame_length;
    logic       is_last;
    logic       checksum_ok;
    logic       empty_frame;
  } frame_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] data_byte_o;
  logic [4:0] byte_index_o;
  logic [4:0] frame_length_o;
  logic       is_last_o;
  logic       checksum_ok_o;
  logic       empty_frame_o;

  // Idle phases: none, sender gaps, receiver stalls, both.
  int idle_pct  [4] = '{0, 50, 0, 29};
  int stall_pct [4] = '{0, 0, 50, 29};
  int cur_phase     = 0;
  bit draining      = 1'b0;
  int error_count   = 0;

  logic [7:0]    frame_window [WIN_DEPTH];
  int            window_count = 0;
  frame_result_t expected_results [$];
  logic [7:0]    tx_bytes [$];
  int            tx_phase [$];

  sync_length_frame_deframer_core #(
    .MAX_DATA_LEN(MAX_DATA_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .frame_length_o(frame_length_o),
    .is_last_o     (is_last_o),
    .checksum_ok_o (checksum_ok_o),
    .empty_frame_o (empty_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  task automatic drop_bytes(input int unsigned n);
    int i;
    if (n >= window_count) begin
      window_count = 0;
    end else begin
      for (i = 0; i < window_count - n; i++) frame_window[i] = frame_window[i + n];
      window_count -= n;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int unsigned   len;
    int unsigned   i;
    logic [7:0]    xsum;
    frame_result_t r;
    if (window_count < WIN_DEPTH) begin
      frame_window[window_count] = b;
      window_count++;
    end
    while (window_count >= MIN_SCAN_FILL) begin
      if (frame_window[0] != SYNC1_BYTE) begin
        drop_bytes(1);
        continue;
      end
      if (frame_window[1] != SYNC2_BYTE) begin
        drop_bytes(2);
        continue;
      end
      if ({1'b0, frame_window[2]} + {1'b0, frame_window[3]} != LEN_SUM) begin
        drop_bytes(4);
        continue;
      end
      len = frame_window[2];
      if (len > MAX_DATA_LEN) begin
        drop_bytes(4);
        continue;
      end
      if (window_count <= len + HDR_BYTES) break;
      if (frame_window[HDR_BYTES + len] != END_BYTE) begin
        drop_bytes(1);
        continue;
      end
      if (len == 0) begin
        r.data_byte    = 8'h00;
        r.byte_index   = 5'd0;
        r.frame_length = 5'd0;
        r.is_last      = 1'b1;
        r.checksum_ok  = 1'b0;
        r.empty_frame  = 1'b1;
        expected_results.push_back(r);
      end else begin
        xsum = 8'h00;
        for (i = 0; i + 1 < len; i++) xsum ^= frame_window[HDR_BYTES + i];
        for (i = 0; i < len; i++) begin
          r.data_byte    = frame_window[HDR_BYTES + i];
          r.byte_index   = i[4:0];
          r.frame_length = len[4:0];
          r.is_last      = (i + 1 == len);
          r.checksum_ok  = (xsum == frame_window[HDR_BYTES + len - 1]);
          r.empty_frame  = 1'b0;
          expected_results.push_back(r);
        end
      end
      drop_bytes(len + FRAME_EXTRA);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
  endtask

  // good_sum forces the final data byte to the XOR of the others
  task automatic add_frame(input int len, input bit good_sum, input logic [7:0] end_byte);
    logic [7:0] d;
    logic [7:0] xsum;
    int         i;
    xsum = 8'h00;
    add_byte(SYNC1_BYTE);
    add_byte(SYNC2_BYTE);
    add_byte(len[7:0]);
    add_byte(~len[7:0]);
    for (i = 0; i < len; i++) begin
      d = $urandom_range(255);
      if (good_sum && i == len - 1) d = xsum;
      xsum ^= d;
      add_byte(d);
    end
    add_byte(end_byte);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6);
    if (r < 90) return $urandom_range(MAX_DATA_LEN - 1, 7);
    return MAX_DATA_LEN;
  endfunction

  initial begin
    int         kind;
    int         len;
    int         i;
    logic [7:0] b;

    // empty frame, length-1 frame with zero data, extreme noise, oversize
    // length with a valid complement, length with a broken complement
    add_frame(0, 1'b0, END_BYTE);
    add_frame(1, 1'b1, END_BYTE);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(SYNC1_BYTE);
    add_byte(SYNC2_BYTE);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(SYNC1_BYTE);
    add_byte(SYNC2_BYTE);
    add_byte(8'h00);
    add_byte(8'h00);

    while (tx_bytes.size() < STIM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        add_frame(pick_len(), $urandom_range(1), END_BYTE);
      end else if (kind < 62) begin
        b = $urandom_range(255);
        if (b == SYNC2_BYTE) b = ~SYNC2_BYTE;
        add_byte(SYNC1_BYTE);
        add_byte(b);
      end else if (kind < 69) begin
        len = $urandom_range(255);
        add_byte(SYNC1_BYTE);
        add_byte(SYNC2_BYTE);
        add_byte(len[7:0]);
        add_byte(~len[7:0] ^ (8'h01 << $urandom_range(7)));
      end else if (kind < 75) begin
        len = $urandom_range(255, MAX_DATA_LEN + 1);
        add_byte(SYNC1_BYTE);
        add_byte(SYNC2_BYTE);
        add_byte(len[7:0]);
        add_byte(~len[7:0]);
      end else if (kind < 82) begin
        b = $urandom_range(255);
        if (b == END_BYTE) b = ~END_BYTE;
        add_frame(pick_len(), $urandom_range(1), b);
      end else if (kind < 90) begin
        // long header whose end check fails later, hiding short frames that
        // then complete together in one rescan
        add_byte(SYNC1_BYTE);
        add_byte(SYNC2_BYTE);
        add_byte(MAX_DATA_LEN[7:0]);
        add_byte(~MAX_DATA_LEN[7:0]);
        for (i = 0; i < 3; i++) add_frame($urandom_range(2), 1'b1, END_BYTE);
      end else begin
        for (i = 0; i < $urandom_range(4, 1); i++) add_byte($urandom_range(255));
      end
    end
    foreach (tx_bytes[k]) tx_phase.push_back(k * 4 / tx_bytes.size());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tx_bytes.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    draining = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("sync_length_frame_deframer_core: match");
    else
      $display("sync_length_frame_deframer_core: mismatch");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("sync_length_frame_deframer_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= idle_pct[tx_phase[0]]) begin
          cur_phase  <= tx_phase.pop_front();
          rx_byte_i  <= tx_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer expected none, actual data_byte %0d index %0d",
                   $time, data_byte_o, byte_index_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("byte_index", want.byte_index, byte_index_o);
          check_field("frame_length", want.frame_length, frame_length_o);
          check_field("is_last", want.is_last, is_last_o);
          check_field("checksum_ok", want.checksum_ok, checksum_ok_o);
          check_field("empty_frame", want.empty_frame, empty_frame_o);
        end
      end
      out_stall_i <= !draining && ($urandom_range(99) < stall_pct[cur_phase]);
    end
  end

endmodule
